FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cps_pkg.sv
// Types and codes shared by the cyclic partition scheduler modules.
package cps_pkg;

    // Request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_LOAD = 2'd1;
    localparam logic [1:0] REQ_KILL = 2'd2;

    // Result action codes
    localparam logic [2:0] ACT_CONTINUE    = 3'd0;
    localparam logic [2:0] ACT_SWITCH      = 3'd1;
    localparam logic [2:0] ACT_STAY_IDLE   = 3'd2;
    localparam logic [2:0] ACT_LOADED      = 3'd3;
    localparam logic [2:0] ACT_KILL_DONE   = 3'd4;
    localparam logic [2:0] ACT_KILL_REJECT = 3'd5;

    // Configuration register indexes
    localparam logic CFG_MAJOR_CYCLE = 1'b0;
    localparam logic CFG_SLOTS_IN_USE = 1'b1;

    // Reset value of the major cycle length
    localparam logic [31:0] MAJOR_RESET = 32'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_cps_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic issue;
        logic finish;
    } t_cps_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_req;
        logic scan_done;
    } t_cps_status;

endpackage

FILE: rtl/core/cps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cps_ctrl.sv
// Controller state machine that sequences capture, table scan and result.
module cps_ctrl import cps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_cps_status i_status,
    output t_cps_cmd    o_cmd,
    output logic        o_busy
);

    t_cps_state r_state;
    t_cps_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_status.scan_req ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.capture = i_start;
            end
            ST_SCAN: begin
                o_cmd.issue = !i_status.scan_done;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/cps_datapath.sv
// Datapath: config registers, slot table, tick counter, scan and result.
`include "assert_macros.svh"

module cps_datapath import cps_pkg::*; #(
    parameter int MAX_SLOTS      = 64,
    parameter int NUM_PARTITIONS = 8,
    parameter int TIME_WIDTH     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cps_cmd    i_cmd,
    output t_cps_status o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_slot_index,
    input  logic [31:0] i_slot_start,
    input  logic [31:0] i_slot_end,
    input  logic [3:0]  i_partition_id,
    output logic        o_done,
    output logic [2:0]  o_action,
    output logic [3:0]  o_running_partition,
    output logic [31:0] o_tick_position
);

    localparam int TW   = TIME_WIDTH;
    localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IW   = $clog2(MAX_SLOTS + 1);
    localparam int LW   = (IW > 7) ? IW : 7;
    localparam int CMPW = (TW > 32) ? TW : 32;
    localparam logic [3:0] IDLE_ID = 4'(NUM_PARTITIONS);

    // Configuration and scheduler state
    logic [31:0]   r_major;
    logic [6:0]    r_slots;
    logic [TW-1:0] r_counter;
    logic [3:0]    r_current;
    logic          r_wrapped;

    // Captured request
    logic [1:0]    r_req;
    logic [3:0]    r_pid;

    // Scan control and accumulated flags
    logic [IW-1:0] r_idx;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    logic          r_cont;
    logic          r_found;
    logic [3:0]    r_found_owner;

    // Result registers
    logic          r_out_valid;
    logic [2:0]    r_action;
    logic [3:0]    r_running;
    logic [31:0]   r_tick;

    logic [2:0]    n_action;
    logic [3:0]    n_current;

    logic [LW-1:0]   scan_lim;
    logic [TW-1:0]   tick_inc;
    logic            tick_wrap;
    logic            load_ok;
    logic [3:0]      load_owner;
    logic            time_we;
    logic [2*TW-1:0] time_wdata;
    logic [2*TW-1:0] rd_time;
    logic [TW-1:0]   rd_start;
    logic [TW-1:0]   rd_end;
    logic [3:0]      rd_owner;
    logic            hit_cont;
    logic            hit_start;
    logic            kill_hit;
    logic            owner_we;
    logic [AW-1:0]   owner_waddr;
    logic [3:0]      owner_wdata;
    logic [AW-1:0]   rd_addr;

    // Clamp the scan length to the table depth
    always_comb begin
        if (LW'(r_slots) > LW'(MAX_SLOTS)) begin
            scan_lim = LW'(MAX_SLOTS);
        end else begin
            scan_lim = LW'(r_slots);
        end
    end

    assign o_status.scan_done = LW'(r_idx) >= scan_lim;
    assign o_status.scan_req  = (i_req_type == REQ_TICK) ||
                                ((i_req_type == REQ_KILL) && (i_partition_id < IDLE_ID));

    // Advance the tick counter and detect the cycle wrap
    assign tick_inc  = r_counter + TW'(1);
    assign tick_wrap = CMPW'(tick_inc) >= CMPW'(r_major);

    // Decode a slot load request
    assign load_ok    = 11'(i_slot_index) < 11'(MAX_SLOTS);
    assign load_owner = (i_partition_id > IDLE_ID) ? IDLE_ID : i_partition_id;
    assign time_we    = i_cmd.capture && (i_req_type == REQ_LOAD) && load_ok;
    assign time_wdata = {TW'(i_slot_end), TW'(i_slot_start)};

    // Evaluate the slot read back this cycle
    assign rd_start  = rd_time[TW-1:0];
    assign rd_end    = rd_time[2*TW-1:TW];
    assign hit_cont  = r_pend && (r_req == REQ_TICK) && !r_wrapped &&
                       (rd_start <= r_counter) && (rd_end > r_counter) &&
                       (rd_owner == r_current);
    assign hit_start = r_pend && (r_req == REQ_TICK) && (rd_start == r_counter);
    assign kill_hit  = r_pend && (r_req == REQ_KILL) && (rd_owner == r_pid);

    // Owner table write: kill rewrites to idle, load stores the owner
    assign owner_we    = kill_hit || time_we;
    assign owner_waddr = kill_hit ? r_pend_addr : AW'(i_slot_index);
    assign owner_wdata = kill_hit ? IDLE_ID : load_owner;
    assign rd_addr     = r_idx[AW-1:0];

    cps_ram #(
        .WIDTH (2 * TW),
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (AW'(i_slot_index)),
        .i_wdata (time_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_time)
    );

    cps_ram #(
        .WIDTH (4),
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (owner_we),
        .i_waddr (owner_waddr),
        .i_wdata (owner_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_owner)
    );

    // Decide the result of the finished request
    always_comb begin
        n_action  = ACT_CONTINUE;
        n_current = r_current;
        case (r_req)
            REQ_TICK: begin
                if (r_cont) begin
                    n_action = ACT_CONTINUE;
                end else if (r_found) begin
                    n_action  = ACT_SWITCH;
                    n_current = r_found_owner;
                end else if (r_current == IDLE_ID) begin
                    n_action = ACT_STAY_IDLE;
                end else begin
                    n_action  = ACT_SWITCH;
                    n_current = IDLE_ID;
                end
            end
            REQ_LOAD: begin
                n_action = ACT_LOADED;
            end
            REQ_KILL: begin
                n_action = (r_pid < IDLE_ID) ? ACT_KILL_DONE : ACT_KILL_REJECT;
            end
            default: begin
                n_action = ACT_CONTINUE;
            end
        endcase
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= MAJOR_RESET;
            r_slots <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAJOR_CYCLE:  r_major <= i_cfg_wdata;
                CFG_SLOTS_IN_USE: r_slots <= i_cfg_wdata[6:0];
                default: begin
                    r_slots <= r_slots;
                end
            endcase
        end
    end

    // Hold scheduler control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= TW'(MAJOR_RESET - 32'd1);
            r_current   <= IDLE_ID;
            r_wrapped   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= i_cmd.issue;
            r_out_valid <= i_cmd.finish;
            if (i_cmd.capture && (i_req_type == REQ_TICK)) begin
                r_counter <= tick_wrap ? '0 : tick_inc;
                r_wrapped <= tick_wrap;
            end
            if (i_cmd.finish) begin
                r_current <= n_current;
            end
        end
    end

    // Capture the request, step the scan and gather flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req_type;
            r_pid   <= i_partition_id;
            r_idx   <= '0;
            r_cont  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_idx       <= r_idx + IW'(1);
                r_pend_addr <= rd_addr;
            end
            if (hit_cont) begin
                r_cont <= 1'b1;
            end
            if (hit_start && !r_found) begin
                r_found       <= 1'b1;
                r_found_owner <= rd_owner;
            end
        end
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_action  <= n_action;
            r_running <= n_current;
            r_tick    <= 32'(r_counter);
        end
    end

    assign o_done              = r_out_valid;
    assign o_action            = r_action;
    assign o_running_partition = r_running;
    assign o_tick_position     = r_tick;

    // Results never come in two adjacent cycles
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_out_valid, !r_out_valid, "back-to-back result")
    // A pending table read is never overlapped by a new request
    `ASSERT_ALWAYS(a_pend_no_capture, i_clk, i_rst_n, !(r_pend && i_cmd.capture), "capture during scan")
    // All table reads are consumed before the result is formed
    `ASSERT_ALWAYS(a_finish_drained, i_clk, i_rst_n, !(i_cmd.finish && r_pend), "finish with read in flight")

endmodule

FILE: rtl/core/cyclic_partition_scheduler.sv
// Top level of the cyclic partition scheduler: controller plus datapath.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------------
//  request   | i_start, o_busy       | i_req_type i_slot_index i_slot_start
//            |                       | i_slot_end i_partition_id
//  result    | o_done (one cycle)    | o_action o_running_partition o_tick_position
//  config    | i_cfg_we              | i_cfg_index i_cfg_wdata
//
//  A request is taken when i_start is high and o_busy is low.
//  Tick and kill requests scan the slot table one entry per cycle through the
//  registered read port of the table RAM, over min(slots_in_use, MAX_SLOTS)
//  entries; load, rejected kill and unused request codes skip the scan.
//  o_done is high for one cycle; a new request may be taken in that cycle.
//  Synchronous active-low reset; the slot table itself is not cleared.
//  The receiver cannot stall the result.
module cyclic_partition_scheduler import cps_pkg::*; #(
    parameter int MAX_SLOTS      = 64,
    parameter int NUM_PARTITIONS = 8,
    parameter int TIME_WIDTH     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_slot_index,
    input  logic [31:0] i_slot_start,
    input  logic [31:0] i_slot_end,
    input  logic [3:0]  i_partition_id,
    output logic        o_done,
    output logic [2:0]  o_action,
    output logic [3:0]  o_running_partition,
    output logic [31:0] o_tick_position,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    t_cps_cmd    cmd;
    t_cps_status status;

    // Sequence each request
    cps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // Hold the table and counters, form the result
    cps_datapath #(
        .MAX_SLOTS      (MAX_SLOTS),
        .NUM_PARTITIONS (NUM_PARTITIONS),
        .TIME_WIDTH     (TIME_WIDTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_req_type          (i_req_type),
        .i_slot_index        (i_slot_index),
        .i_slot_start        (i_slot_start),
        .i_slot_end          (i_slot_end),
        .i_partition_id      (i_partition_id),
        .o_done              (o_done),
        .o_action            (o_action),
        .o_running_partition (o_running_partition),
        .o_tick_position     (o_tick_position)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cyclic partition scheduler: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
    import cps_pkg::*;

    localparam int MAX_SLOTS = 64;
    localparam int NUM_PARTITIONS = 8;
    localparam logic [3:0] IDLE_PART = 4'd8;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int LIMIT_CYCLES = 1500000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  index;
        logic [31:0] t_start;
        logic [31:0] t_end;
        logic [3:0]  part;
    } t_request;

    typedef struct {
        logic [2:0]  action;
        logic [3:0]  part;
        logic [31:0] pos;
    } t_result;

    typedef enum {ROW_PREDICT, ROW_TYPED, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_request    rq;
        t_result     want;
        logic        reg_idx;
        logic [31:0] reg_data;
    } t_row;

    // Phase settings: cycle length, slots scanned, sender idle percentage
    localparam logic [31:0] PHASE_MAJOR [N_PHASES] = '{
        32'd16, 32'd1, 32'd0, 32'd40, 32'hFFFF_FFFF, 32'd24, 32'd12, 32'd20};
    localparam logic [6:0] PHASE_SLOTS [N_PHASES] = '{
        7'd8, 7'd64, 7'd127, 7'd20, 7'd4, 7'd64, 7'd0, 7'd100};
    localparam int PHASE_IDLE [3] = '{0, 55, 10};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [5:0]  i_slot_index = '0;
    logic [31:0] i_slot_start = '0;
    logic [31:0] i_slot_end = '0;
    logic [3:0]  i_partition_id = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_busy;
    logic        o_done;
    logic [2:0]  o_action;
    logic [3:0]  o_running_partition;
    logic [31:0] o_tick_position;

    // Scheduler image kept by the testbench
    logic [31:0] tbl_start [MAX_SLOTS];
    logic [31:0] tbl_end [MAX_SLOTS];
    logic [3:0]  tbl_owner [MAX_SLOTS];
    bit          tbl_written [MAX_SLOTS];
    logic [3:0]  run_part = IDLE_PART;
    logic [31:0] tick_cnt = MAJOR_RESET - 32'd1;
    logic [31:0] cycle_len = MAJOR_RESET;
    logic [6:0]  scan_slots = 7'd0;

    t_result     pending_results [$];
    t_row        plan [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          slot_span = 8;
    int          requests_sent = 0;
    int          settings_used = 0;
    int          act_seen [6] = '{default: 0};

    cyclic_partition_scheduler i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_req_type         (i_req_type),
        .i_slot_index       (i_slot_index),
        .i_slot_start       (i_slot_start),
        .i_slot_end         (i_slot_end),
        .i_partition_id     (i_partition_id),
        .o_done             (o_done),
        .o_action           (o_action),
        .o_running_partition(o_running_partition),
        .o_tick_position    (o_tick_position),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    // Generate the 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int scan_limit();
        return (scan_slots > MAX_SLOTS) ? MAX_SLOTS : int'(scan_slots);
    endfunction

    // Advance the scheduler image by one request and return its decision
    function automatic t_result schedule_step(input t_request rq);
        t_result r;
        int      n;
        int      hit;
        bit      cont;
        bit      wrapped;
        n = scan_limit();
        r.action = ACT_CONTINUE;
        case (rq.kind)
            REQ_TICK: begin
                tick_cnt = tick_cnt + 32'd1;
                wrapped = (tick_cnt >= cycle_len);
                if (wrapped)
                    tick_cnt = '0;
                cont = 1'b0;
                if (!wrapped) begin
                    for (int i = 0; i < n; i++)
                        if (tbl_start[i] <= tick_cnt && tbl_owner[i] == run_part &&
                            tbl_end[i] > tick_cnt)
                            cont = 1'b1;
                end
                if (cont) begin
                    r.action = ACT_CONTINUE;
                end else begin
                    hit = -1;
                    for (int i = 0; i < n; i++)
                        if (hit < 0 && tbl_start[i] == tick_cnt)
                            hit = i;
                    if (hit >= 0) begin
                        run_part = tbl_owner[hit];
                        r.action = ACT_SWITCH;
                    end else if (run_part == IDLE_PART) begin
                        r.action = ACT_STAY_IDLE;
                    end else begin
                        run_part = IDLE_PART;
                        r.action = ACT_SWITCH;
                    end
                end
            end
            REQ_LOAD: begin
                tbl_start[rq.index] = rq.t_start;
                tbl_end[rq.index] = rq.t_end;
                tbl_owner[rq.index] = (rq.part > IDLE_PART) ? IDLE_PART : rq.part;
                tbl_written[rq.index] = 1'b1;
                r.action = ACT_LOADED;
            end
            REQ_KILL: begin
                if (rq.part >= NUM_PARTITIONS) begin
                    r.action = ACT_KILL_REJECT;
                end else begin
                    for (int i = 0; i < n; i++)
                        if (tbl_owner[i] == rq.part)
                            tbl_owner[i] = IDLE_PART;
                    r.action = ACT_KILL_DONE;
                end
            end
            default: r.action = ACT_CONTINUE;
        endcase
        r.part = run_part;
        r.pos = tick_cnt;
        return r;
    endfunction

    // Count leading table entries that hold a loaded slot
    function automatic int loaded_prefix();
        int k;
        k = 0;
        while (k < MAX_SLOTS && tbl_written[k])
            k++;
        return k;
    endfunction

    function automatic t_request load_request(input logic [5:0] idx);
        t_request rq;
        rq.kind = REQ_LOAD;
        rq.index = idx;
        rq.t_start = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, slot_span);
        if ($urandom_range(0, 6) == 0)
            rq.t_end = $urandom;
        else
            rq.t_end = rq.t_start + $urandom_range(0, slot_span / 2 + 1);
        rq.part = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 8));
        return rq;
    endfunction

    // Mostly ticks, with loads mostly into the scanned range, kills and stray codes
    function automatic t_request random_request();
        t_request rq;
        int       pick;
        int       n;
        n = scan_limit();
        rq.kind = REQ_TICK;
        rq.index = 6'($urandom_range(0, 63));
        rq.t_start = $urandom;
        rq.t_end = $urandom;
        rq.part = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            rq.kind = REQ_TICK;
        end else if (pick < 82) begin
            if (n > 0 && $urandom_range(0, 4) != 0)
                rq = load_request(6'($urandom_range(0, n - 1)));
            else
                rq = load_request(6'($urandom_range(0, 63)));
        end else if (pick < 94) begin
            rq.kind = REQ_KILL;
            rq.part = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(0, 7));
        end else begin
            rq.kind = REQ_UNUSED;
        end
        return rq;
    endfunction

    // Drive one request, hold it until taken, then record its expectation
    task automatic issue_request(input t_request rq, input bit typed, input t_result want);
        t_result r;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req_type <= rq.kind;
        i_slot_index <= rq.index;
        i_slot_start <= rq.t_start;
        i_slot_end <= rq.t_end;
        i_partition_id <= rq.part;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        r = schedule_step(rq);
        pending_results.push_back(typed ? want : r);
        requests_sent++;
    endtask

    // Drop the request line and wait until every result has come back
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAJOR_CYCLE)
            cycle_len = data;
        else
            scan_slots = data[6:0];
        settings_used++;
    endtask

    function automatic void add_row(input t_row_kind k, input logic [1:0] kind,
                                    input logic [5:0] idx, input logic [31:0] st,
                                    input logic [31:0] en, input logic [3:0] part,
                                    input logic [2:0] act, input logic [31:0] pos);
        t_row row;
        row.kind = k;
        row.rq = '{kind, idx, st, en, part};
        row.want = '{act, IDLE_PART, pos};
        row.reg_idx = 1'b0;
        row.reg_data = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_reg(input logic idx, input logic [31:0] data);
        t_row row;
        row.kind = ROW_REG;
        row.rq = '{default: '0};
        row.want = '{default: '0};
        row.reg_idx = idx;
        row.reg_data = data;
        plan.push_back(row);
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: action %0d part %0d pos %0d",
                             o_action, o_running_partition, o_tick_position);
            end else begin
                want = pending_results.pop_front();
                if (o_action !== want.action || o_running_partition !== want.part ||
                    o_tick_position !== want.pos) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: expected action %0d part %0d pos %0d, got %0d %0d %0d",
                                 want.action, want.part, want.pos,
                                 o_action, o_running_partition, o_tick_position);
                end
                if (want.action <= ACT_KILL_REJECT)
                    act_seen[want.action]++;
            end
        end
    end

    initial begin
        t_result none;
        t_request rq;
        int n;
        none = '{default: '0};

        // Directed table: reset state, extremes and every request code
        add_row(ROW_TYPED, REQ_TICK, 6'd0, 32'd0, 32'd0, 4'd0, ACT_STAY_IDLE, 32'd0);
        add_row(ROW_TYPED, REQ_UNUSED, 6'h3F, '1, '1, 4'hF, ACT_CONTINUE, 32'd0);
        add_row(ROW_TYPED, REQ_KILL, 6'd0, 32'd0, 32'd0, 4'd8, ACT_KILL_REJECT, 32'd0);
        add_row(ROW_TYPED, REQ_KILL, 6'd0, 32'd0, 32'd0, 4'd15, ACT_KILL_REJECT, 32'd0);
        add_row(ROW_TYPED, REQ_KILL, 6'd0, 32'd0, 32'd0, 4'd0, ACT_KILL_DONE, 32'd0);
        add_row(ROW_TYPED, REQ_LOAD, 6'd0, 32'd1, 32'd4, 4'd2, ACT_LOADED, 32'd0);
        add_row(ROW_TYPED, REQ_LOAD, 6'd1, 32'd2, 32'd3, 4'd12, ACT_LOADED, 32'd0);
        add_row(ROW_TYPED, REQ_LOAD, 6'd63, 32'hFFFF_FFFF, 32'd0, 4'd15, ACT_LOADED, 32'd0);
        add_row(ROW_TYPED, REQ_LOAD, 6'd2, 32'd4, 32'hFFFF_FFFF, 4'd0, ACT_LOADED, 32'd0);
        add_row(ROW_TYPED, REQ_LOAD, 6'd3, 32'd0, 32'd0, 4'd7, ACT_LOADED, 32'd0);
        add_reg(CFG_SLOTS_IN_USE, 32'd4);
        add_reg(CFG_MAJOR_CYCLE, 32'd6);
        for (int i = 0; i < 4; i++)
            add_row(ROW_PREDICT, REQ_TICK, 6'd0, 32'd0, 32'd0, 4'd0, ACT_CONTINUE, 32'd0);
        add_row(ROW_PREDICT, REQ_KILL, 6'd0, 32'd0, 32'd0, 4'd2, ACT_CONTINUE, 32'd0);
        for (int i = 0; i < 4; i++)
            add_row(ROW_PREDICT, REQ_TICK, 6'd0, 32'd0, 32'd0, 4'd0, ACT_CONTINUE, 32'd0);
        add_reg(CFG_MAJOR_CYCLE, 32'd0);
        add_row(ROW_PREDICT, REQ_TICK, 6'd0, 32'd0, 32'd0, 4'd0, ACT_CONTINUE, 32'd0);
        add_reg(CFG_MAJOR_CYCLE, 32'd1);
        add_row(ROW_PREDICT, REQ_KILL, 6'd0, 32'd0, 32'd0, 4'd7, ACT_CONTINUE, 32'd0);
        add_row(ROW_PREDICT, REQ_TICK, 6'd0, 32'd0, 32'd0, 4'd0, ACT_CONTINUE, 32'd0);

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG)
                write_reg(plan[k].reg_idx, plan[k].reg_data);
            else
                issue_request(plan[k].rq, plan[k].kind == ROW_TYPED, plan[k].want);
        end

        // Random phases: load any unwritten scanned entries, then reconfigure and run
        for (int ph = 0; ph < N_PHASES; ph++) begin
            sender_idle_pct = PHASE_IDLE[ph % 3];
            if (PHASE_MAJOR[ph] == 0)
                slot_span = 8;
            else if (PHASE_MAJOR[ph] > 200)
                slot_span = 160;
            else
                slot_span = PHASE_MAJOR[ph];
            n = (PHASE_SLOTS[ph] > MAX_SLOTS) ? MAX_SLOTS : int'(PHASE_SLOTS[ph]);
            for (int k = loaded_prefix(); k < n; k = loaded_prefix()) begin
                rq = load_request(k[5:0]);
                issue_request(rq, 1'b0, none);
            end
            write_reg(CFG_MAJOR_CYCLE, PHASE_MAJOR[ph]);
            write_reg(CFG_SLOTS_IN_USE, {25'd0, PHASE_SLOTS[ph]});
            repeat (ITEMS_PER_PHASE) begin
                rq = random_request();
                issue_request(rq, 1'b0, none);
            end
        end

        // Drain and give a late result time to show up
        wait_idle();
        repeat (MAX_SLOTS + 8) @(posedge i_clk);

        $display("Ran %0d requests under %0d register writes across %0d phases",
                 requests_sent, settings_used, N_PHASES);
        $display("Seen: %0d continue, %0d switch, %0d idle, %0d load, %0d kill, %0d reject",
                 act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4], act_seen[5]);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
